// File: rtl/core/rlsd_pkg.sv
// ----------------------------------------------------------------------------
// LED strip frame driver package
// Shared constants, opcode and state types, pixel layout and the brightness
// conversion used by the pixel store and the frame serializer.
// ----------------------------------------------------------------------------
package rlsd_pkg;

    // Number of LEDs on the strip and derived widths.
    localparam int LED_COUNT = 8;
    localparam int IDX_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int WORDS     = LED_COUNT + 2;
    localparam int WCNT_W    = $clog2(WORDS);

    // Frame words are built one byte per cycle, most significant byte first.
    localparam int BYTES_PER_WORD = 4;
    localparam int BCNT_W         = $clog2(BYTES_PER_WORD);

    localparam logic [7:0] START_BYTE = 8'h00;
    localparam logic [7:0] END_BYTE   = 8'hFF;
    localparam logic [2:0] LED_PREFIX = 3'b111;
    localparam logic [4:0] BRIGHT_MAX = 5'd31;

    typedef enum logic [2:0] {
        OP_SET_LED        = 3'd0,
        OP_SET_ALL        = 3'd1,
        OP_SET_BRIGHT     = 3'd2,
        OP_SET_ALL_BRIGHT = 3'd3,
        OP_CLEAR          = 3'd4,
        OP_REFRESH        = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        SER_IDLE  = 2'd0,
        SER_BUILD = 2'd1,
        SER_LOAD  = 2'd2
    } ser_state_t;

    typedef struct packed {
        logic [4:0] bright;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    // One write command into the pixel store.
    typedef struct packed {
        logic               valid;
        opcode_t            op;
        logic [5:0]         idx;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic signed [9:0]  q;
    } store_cmd_t;

    // Level for a Q1.8 brightness that is not negative: 31 at or above one,
    // otherwise floor(31 * q / 256), formed as (q << 5) - q.
    function automatic logic [4:0] level_of(input logic signed [9:0] q);
        logic [12:0] prod;
        prod = {q[7:0], 5'b0} - {5'b0, q[7:0]};
        if (q[8])
            return BRIGHT_MAX;
        return prod[12:8];
    endfunction

endpackage

// File: rtl/core/rlsd_store.sv
// ----------------------------------------------------------------------------
// LED strip pixel store
// Holds brightness and color for every LED, applies the write opcodes and
// offers one pixel at a time to the serializer.
// ----------------------------------------------------------------------------
module rlsd_store
    import rlsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  store_cmd_t       cmd,
    input  logic [IDX_W-1:0] rd_idx,
    output pixel_t           rd_pixel
);

    pixel_t     pixel_reg  [LED_COUNT];
    pixel_t     pixel_next [LED_COUNT];
    logic [4:0] level;
    logic       neg;

    assign level = level_of(cmd.q);
    assign neg   = cmd.q[9];

    always_comb
    begin
        for (int i = 0; i < LED_COUNT; i++)
        begin
            pixel_next[i] = pixel_reg[i];
            if (cmd.valid)
            begin
                unique case (cmd.op) inside
                    OP_SET_LED, OP_SET_ALL:
                    begin
                        if (cmd.op == OP_SET_ALL || cmd.idx == 6'(i))
                        begin
                            if (!neg)
                                pixel_next[i].bright = level;
                            pixel_next[i].blue  = cmd.blue;
                            pixel_next[i].green = cmd.green;
                            pixel_next[i].red   = cmd.red;
                        end
                    end
                    OP_SET_BRIGHT, OP_SET_ALL_BRIGHT:
                    begin
                        if (cmd.op == OP_SET_ALL_BRIGHT || cmd.idx == 6'(i))
                            pixel_next[i].bright = neg ? 5'd0 : level;
                    end
                    OP_CLEAR:
                        pixel_next[i] = '0;
                    default:
                        pixel_next[i] = pixel_reg[i];
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LED_COUNT; i++)
                pixel_reg[i] <= '0;
        end
        else
        begin
            for (int i = 0; i < LED_COUNT; i++)
                pixel_reg[i] <= pixel_next[i];
        end
    end

    always_comb
    begin
        rd_pixel = '0;
        for (int i = 0; i < LED_COUNT; i++)
        begin
            if (rd_idx == IDX_W'(i))
                rd_pixel = pixel_reg[i];
        end
    end

endmodule

// File: rtl/core/rlsd_serializer.sv
// ----------------------------------------------------------------------------
// LED strip frame serializer
// Builds the start word, one word per LED and the end word, shifting each
// word together one byte per cycle, and holds it in the output register.
// ----------------------------------------------------------------------------
module rlsd_serializer
    import rlsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic [IDX_W-1:0] rd_idx,
    input  pixel_t           rd_pixel,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      frame_word,
    output logic             last_word
);

    localparam logic [WCNT_W-1:0] LAST_WORD = WCNT_W'(WORDS - 1);

    ser_state_t        state_reg, state_next;
    logic [WCNT_W-1:0] word_cnt_reg, word_cnt_next;
    logic [BCNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic [31:0]       shift_reg, shift_next;
    logic [31:0]       out_word_reg, out_word_next;
    logic              out_last_reg, out_last_next;
    logic              out_valid_reg, out_valid_next;
    logic [WCNT_W-1:0] led_sel;
    logic [7:0]        digit;

    assign led_sel = word_cnt_reg - WCNT_W'(1);
    assign rd_idx  = led_sel[IDX_W-1:0];

    // Byte of the current word for the current byte position.
    always_comb
    begin
        if (word_cnt_reg == '0)
            digit = START_BYTE;
        else if (word_cnt_reg == LAST_WORD)
            digit = END_BYTE;
        else
        begin
            case (byte_cnt_reg)
                2'd0:    digit = {LED_PREFIX, rd_pixel.bright};
                2'd1:    digit = rd_pixel.blue;
                2'd2:    digit = rd_pixel.green;
                default: digit = rd_pixel.red;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        word_cnt_next  = word_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        shift_next     = shift_reg;
        out_word_next  = out_word_reg;
        out_last_next  = out_last_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            SER_IDLE:
            begin
                if (start)
                begin
                    word_cnt_next = '0;
                    byte_cnt_next = '0;
                    state_next    = SER_BUILD;
                end
            end
            SER_BUILD:
            begin
                shift_next    = {shift_reg[23:0], digit};
                byte_cnt_next = byte_cnt_reg + BCNT_W'(1);
                if (byte_cnt_reg == BCNT_W'(BYTES_PER_WORD - 1))
                    state_next = SER_LOAD;
            end
            SER_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_word_next  = shift_reg;
                    out_last_next  = (word_cnt_reg == LAST_WORD);
                    out_valid_next = 1'b1;
                    if (word_cnt_reg == LAST_WORD)
                        state_next = SER_IDLE;
                    else
                    begin
                        word_cnt_next = word_cnt_reg + WCNT_W'(1);
                        byte_cnt_next = '0;
                        state_next    = SER_BUILD;
                    end
                end
            end
            default:
                state_next = SER_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SER_IDLE;
            word_cnt_reg  <= '0;
            byte_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            word_cnt_reg  <= word_cnt_next;
            byte_cnt_reg  <= byte_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg    <= shift_next;
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
    end

    assign busy       = (state_reg != SER_IDLE);
    assign out_valid  = out_valid_reg;
    assign frame_word = out_word_reg;
    assign last_word  = out_last_reg;

endmodule

// File: rtl/core/rgb_led_strip_frame_driver.sv
// ----------------------------------------------------------------------------
// RGB LED strip frame driver
// Pixel store for an addressable LED strip with a refresh that emits the
// frame as 32-bit words: a zero start word, one word per LED and an end word.
// ----------------------------------------------------------------------------
// Store operations (set one LED, set all, set one or all brightness, clear)
// are taken one per cycle while no refresh runs and produce no output
// words. Brightness arrives as signed Q1.8 and is stored as a 5-bit level,
// 31 at or above one and floor(31 * v) below; a negative value keeps the
// old level on color writes and stores zero on brightness writes. Indices at
// or above the LED count are ignored, and opcodes six and seven do nothing.
// A refresh holds the input channel while it emits LED_COUNT + 2 words:
// each word is shifted together one byte per cycle in the serializer and
// then moved into the output register. A finished word waits while the
// output register still holds a word that the receiver has not taken, and
// every such cycle adds to the refresh. The end word is flagged with
// last_word. Once the last word sits in the output register, the next input
// word is accepted even if that word has not been taken yet.
// ----------------------------------------------------------------------------
module rgb_led_strip_frame_driver
    import rlsd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  opcode,
    input  logic [5:0]  led_index,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic signed [9:0] brightness_q,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] frame_word,
    output logic        last_word
);

    store_cmd_t       cmd;
    logic             accept;
    logic             busy;
    logic             start;
    logic [IDX_W-1:0] rd_idx;
    pixel_t           rd_pixel;
    opcode_t          op;

    // The store is never written while a refresh reads it, since no input
    // word is accepted until the serializer has gone idle.
    assign in_ready = !busy;
    assign accept   = in_valid && in_ready;
    assign op       = opcode_t'(opcode);
    assign start    = accept && (op == OP_REFRESH);

    always_comb
    begin
        cmd.valid = accept && (op != OP_REFRESH);
        cmd.op    = op;
        cmd.idx   = led_index;
        cmd.red   = red;
        cmd.green = green;
        cmd.blue  = blue;
        cmd.q     = brightness_q;
    end

    rlsd_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .rd_idx   (rd_idx),
        .rd_pixel (rd_pixel)
    );

    rlsd_serializer u_serializer (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .rd_idx     (rd_idx),
        .rd_pixel   (rd_pixel),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .frame_word (frame_word),
        .last_word  (last_word)
    );

endmodule
